// ===== sv/adrda_pkg.sv =====
// ----------------------------------------------------------------------------
// adrda_pkg
// Shared types and constants of the AdaGrad dual-averaging L1 update block.
// ----------------------------------------------------------------------------
package adrda_pkg;

  localparam int unsigned NumCoordsDef = 1024;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned GradW        = 32;
  localparam int unsigned CfgW         = 31;
  localparam int unsigned SumW         = 48;
  localparam int unsigned SqW          = 64;
  localparam int unsigned StepW        = 32;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [CfgIdxW-1:0] RegL1Threshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStepRate    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDenomOffset = 2'd2;

  typedef enum logic [3:0] {
    BkIdle,
    BkRead,
    BkAcc,
    BkAvg,
    BkSqrt,
    BkDen,
    BkFact,
    BkMul,
    BkMul2,
    BkOut
  } bk_state_e;

  // Item handed from front to back.
  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic signed [GradW-1:0] grad;
    logic                    last;
  } item_t;

  // Result word of the output channel.
  typedef struct packed {
    logic [IdxW-1:0]         out_index;
    logic signed [GradW-1:0] weight_value;
    logic                    saturated;
  } result_t;

endpackage

// ===== sv/adrda_if.sv =====
// ----------------------------------------------------------------------------
// adrda_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface adrda_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/adagrad_dual_avg_l1_update_unit.sv =====
// Flow: each accepted item is read, accumulated, then run through the average
// divide, the square root, the factor divide and the split multiply.
// The engine works on one item at a time; a 2-entry queue decouples the input,
// and a held result stalls the engine.
// Reset: registers take their reset values at once; then a clearing pass
// over every address zeroes the sum memories before the first item is taken.
// ----------------------------------------------------------------------------
// adagrad_dual_avg_l1_update_unit
// Top level: config registers, input queue and update engine.
// ----------------------------------------------------------------------------
module adagrad_dual_avg_l1_update_unit import adrda_pkg::*; #(
  parameter int unsigned NumCoords = NumCoordsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  adrda_if.sink              in_ch,
  adrda_if.source            out_ch
);
  logic [CfgW-1:0] l1_q, rate_q, doff_q;
  logic  q_valid, q_pop;
  item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q   <= '0;
      rate_q <= CfgW'(65536);
      doff_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegL1Threshold: l1_q   <= cfg_wdata_i;
        RegStepRate:    rate_q <= cfg_wdata_i;
        RegDenomOffset: doff_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  adrda_front #(.NumCoords(NumCoords)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .coord_index_i(in_ch.data.idx), .grad_value_i(in_ch.data.grad),
    .last_in_instance_i(in_ch.data.last),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  adrda_back #(.NumCoords(NumCoords), .FracBits(FracBits)) u_back (
    .clk_i, .rst_ni,
    .l1_q_i(l1_q), .rate_q_i(rate_q), .doff_q_i(doff_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_index_o(out_ch.data.out_index), .weight_value_o(out_ch.data.weight_value),
    .saturated_o(out_ch.data.saturated)
  );
endmodule

// ===== sv/adrda_ram.sv =====
// ----------------------------------------------------------------------------
// adrda_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module adrda_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== sv/adrda_front.sv =====
// ----------------------------------------------------------------------------
// adrda_front
// Accepts items, reduces the index and queues them for the back end.
// ----------------------------------------------------------------------------
module adrda_front import adrda_pkg::*; #(
  parameter int unsigned NumCoords = NumCoordsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IdxW-1:0]       coord_index_i,
  input  logic signed [GradW-1:0] grad_value_i,
  input  logic                  last_in_instance_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output item_t                 q_item_o
);
  localparam int unsigned Depth      = 2;
  localparam int unsigned RecipShift = 2 * IdxW;
  localparam logic [RecipShift-1:0] RecipMul = RecipShift'((1 << RecipShift) / NumCoords);
  localparam logic [IdxW:0] NumCoordsW = (IdxW+1)'(NumCoords);

  item_t      buf_q [Depth];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      it;
  logic [IdxW:0] red;
  logic [RecipShift+IdxW-1:0] mprod;
  logic [IdxW-1:0]            qest;
  logic [2*IdxW:0]            qn;

  // Reduce the index modulo the coordinate count: the reciprocal estimate of
  // the quotient is low by at most one, so one conditional subtract finishes.
  always_comb begin
    mprod = (RecipShift+IdxW)'(coord_index_i) * (RecipShift+IdxW)'(RecipMul);
    qest  = mprod[RecipShift +: IdxW];
    qn    = (2*IdxW+1)'(qest) * (2*IdxW+1)'(NumCoordsW);
    red   = {1'b0, coord_index_i};
    if (NumCoords < (1 << IdxW)) begin
      red = {1'b0, coord_index_i} - qn[IdxW:0];
      if (red >= NumCoordsW) begin
        red = red - NumCoordsW;
      end
    end
    it.idx  = red[IdxW-1:0];
    it.grad = grad_value_i;
    it.last = last_in_instance_i;
  end

  assign in_ready_o = (cnt_q != 2'(Depth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = q_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= it;
    end
  end
endmodule

// ===== sv/adrda_back.sv =====
// ----------------------------------------------------------------------------
// adrda_back
// Updates the per-coordinate sums and computes the shrunk weight.
// ----------------------------------------------------------------------------
module adrda_back import adrda_pkg::*; #(
  parameter int unsigned NumCoords = NumCoordsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CfgW-1:0]         l1_q_i,
  input  logic [CfgW-1:0]         rate_q_i,
  input  logic [CfgW-1:0]         doff_q_i,
  input  logic                    q_valid_i,
  output logic                    q_pop_o,
  input  item_t                   q_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IdxW-1:0]         out_index_o,
  output logic signed [GradW-1:0] weight_value_o,
  output logic                    saturated_o
);
  localparam int unsigned AW = $clog2(NumCoords);
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [63:0] Lim31 = 64'h7FFF_FFFF;

  bk_state_e st_q, st_d;

  // clearing pass
  logic          clr_q;
  logic [AW:0]   clr_cnt_q;

  item_t         it_q;
  logic [AW-1:0] addr;
  logic          we;
  logic [SumW-1:0] s_wr, s_rd;
  logic [SqW-1:0]  q_wr, q_rd;

  logic [SqW-1:0]  sq_q;
  logic            sat_q, neg_q;
  logic [StepW-1:0] step_q;

  // shared iteration counter and work registers
  logic [6:0]  k_q;
  logic [SumW-1:0] rem_q, quo_q;          // avg divide
  logic [SqW-1:0]  sv_q, sr_q, sb_q;      // isqrt
  logic [63:0]     den_q, fq_q;           // factor divide
  logic [63:0]     frem_q;
  logic [63:0]     diff_q;
  logic [63:0]     p0_q, p1_q, p2_q, p3_q; // partial products
  logic [127:0]    prod;
  logic [63:0]     mag;
  logic            msat;
  logic            out_v_q;
  logic [IdxW-1:0] o_idx_q;
  logic [GradW-1:0] o_w_q;
  logic            o_sat_q;

  assign addr = clr_q ? clr_cnt_q[AW-1:0] : AW'(it_q.idx);
  assign we   = clr_q || (st_q == BkAcc);

  adrda_ram #(.Width(SumW), .Depth(NumCoords)) u_sum (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(s_wr), .rdata_o(s_rd)
  );
  adrda_ram #(.Width(SqW), .Depth(NumCoords)) u_sq (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(q_wr), .rdata_o(q_rd)
  );

  // accumulate
  logic signed [SumW:0] s_ext;
  logic [GradW-1:0]     gmag;
  logic [SqW-1:0]       gsq;
  logic [SqW:0]         q_ext;
  logic                 s_hi, s_lo, q_ov;
  always_comb begin
    s_ext = $signed({s_rd[SumW-1], s_rd}) + (SumW+1)'($signed(it_q.grad));
    s_hi  = s_ext > $signed({1'b0, SumMax});
    s_lo  = s_ext < $signed({1'b1, SumMin});
    gmag  = it_q.grad[GradW-1] ? (~it_q.grad + 1'b1) : it_q.grad;
    gsq   = SqW'(gmag) * SqW'(gmag);
    q_ext = {1'b0, q_rd} + {1'b0, gsq};
    q_ov  = q_ext[SqW];
    if (clr_q) begin
      s_wr = '0;
      q_wr = '0;
    end else begin
      s_wr = s_hi ? SumMax : (s_lo ? SumMin : s_ext[SumW-1:0]);
      q_wr = q_ov ? '1 : q_ext[SqW-1:0];
    end
  end

  // restoring divide step of sum magnitude by the step count
  logic [SumW:0] dv_try;
  assign dv_try = {rem_q, quo_q[SumW-1]} - (SumW+1)'(step_q);

  // isqrt step
  logic [SqW-1:0] sqt;
  assign sqt = sr_q + sb_q;

  // factor divide step
  logic [64:0] fd_try;
  assign fd_try = {frem_q, fq_q[63]} - {1'b0, den_q};

  assign prod = {64'b0, p0_q} + {32'b0, p1_q, 32'b0} + {32'b0, p2_q, 32'b0} + {p3_q, 64'b0};

  always_comb begin
    msat = 1'b0;
    mag  = prod[FracBits +: 64];
    if (prod[127 -: (64 - FracBits)] != '0) begin
      msat = 1'b1;
    end
  end

  logic [63:0] lim;
  logic [63:0] den_raw;
  always_comb begin
    den_raw = 64'(doff_q_i) + sr_q;
    lim     = neg_q ? Lim31 : (Lim31 + 64'd1);
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle: if (!clr_q && q_valid_i) st_d = BkRead;
      BkRead: st_d = BkAcc;
      BkAcc:  st_d = BkAvg;
      BkAvg:  if (k_q == 7'(SumW)) st_d = BkSqrt;
      BkSqrt: if (sb_q == '0) st_d = BkDen;
      BkDen:  st_d = BkFact;
      BkFact: if (k_q == 7'd64) st_d = BkMul;
      BkMul:  st_d = BkMul2;
      BkMul2: st_d = BkOut;
      BkOut:  if (!out_v_q) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  assign q_pop_o = (st_q == BkIdle) && !clr_q && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= BkIdle;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      step_q    <= StepW'(1);
      out_v_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (AW+1)'(NumCoords - 1)) clr_q <= 1'b0;
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (st_q == BkMul2) begin
        out_v_q <= 1'b1;
        if (it_q.last && step_q != '1) step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      BkIdle: begin
        it_q <= q_item_i;
      end
      BkAcc: begin
        sq_q  <= q_wr;
        sat_q <= s_hi || s_lo || q_ov;
        neg_q <= s_wr[SumW-1];
        rem_q <= '0;
        quo_q <= s_wr[SumW-1] ? (~s_wr + 1'b1) : s_wr;
        k_q   <= '0;
      end
      BkAvg: begin
        if (k_q != 7'(SumW)) begin
          if (!dv_try[SumW]) begin
            rem_q <= dv_try[SumW-1:0];
            quo_q <= {quo_q[SumW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[SumW-2:0], quo_q[SumW-1]};
            quo_q <= {quo_q[SumW-2:0], 1'b0};
          end
          k_q <= k_q + 1'b1;
        end else begin
          sv_q <= sq_q;
          sr_q <= '0;
          sb_q <= 64'h4000_0000_0000_0000;
        end
      end
      BkSqrt: begin
        if (sb_q != '0) begin
          if (sv_q >= sqt) begin
            sv_q <= sv_q - sqt;
            sr_q <= (sr_q >> 1) + sb_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sb_q <= sb_q >> 2;
        end
      end
      BkDen: begin
        den_q   <= (den_raw == '0) ? 64'd1 : den_raw;
        fq_q    <= 64'(rate_q_i) << FracBits;
        frem_q  <= '0;
        k_q     <= '0;
        diff_q  <= 64'(quo_q) - 64'(l1_q_i);
      end
      BkFact: begin
        if (k_q != 7'd64) begin
          if (!fd_try[64]) begin
            frem_q <= fd_try[63:0];
            fq_q   <= {fq_q[62:0], 1'b1};
          end else begin
            frem_q <= {frem_q[62:0], fq_q[63]};
            fq_q   <= {fq_q[62:0], 1'b0};
          end
          k_q <= k_q + 1'b1;
        end
      end
      BkMul: begin
        // split factor and diff into 32-bit halves
        p0_q <= 64'(fq_q[31:0]) * 64'(diff_q[31:0]);
        p1_q <= 64'(fq_q[63:32]) * 64'(diff_q[31:0]);
        p2_q <= 64'(fq_q[31:0]) * 64'(diff_q[63:32]);
        p3_q <= 64'(fq_q[63:32]) * 64'(diff_q[63:32]);
      end
      BkMul2: begin
        o_idx_q <= it_q.idx;
        if (64'(quo_q) <= 64'(l1_q_i)) begin
          o_w_q   <= '0;
          o_sat_q <= sat_q;
        end else if (msat || mag > lim) begin
          o_w_q   <= neg_q ? lim[31:0] : (~lim[31:0] + 1'b1);
          o_sat_q <= 1'b1;
        end else begin
          o_w_q   <= neg_q ? mag[31:0] : (~mag[31:0] + 1'b1);
          o_sat_q <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_v_q;
  assign out_index_o    = o_idx_q;
  assign weight_value_o = o_w_q;
  assign saturated_o    = o_sat_q;
endmodule
